>>> hdl/srtq_pkg.sv
// srtq_pkg: codes, microcode table and shared types of the sequenced ring queue.
// No dependencies; imported by every module of the block.
package srtq_pkg;

  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int SEQ_W  = 31;
  localparam int LAST_W = 32;
  localparam int STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  // request kinds
  localparam logic [KIND_W-1:0] K_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] K_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] K_READ = 2'd2;
  localparam logic [KIND_W-1:0] K_NOP  = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_SKIP  = 3'd4;

  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ENQ,
    A_DEQ_CHK,
    A_DEQ_OUT,
    A_RD_CHK,
    A_RD_ADDR,
    A_RD_OUT,
    A_NOP
  } act_t;

  typedef enum logic [1:0] {
    J_KIND,
    J_NEXT,
    J_HOME,
    J_HOME_EMPTY
  } jmp_t;

  typedef struct packed {
    act_t act;
    jmp_t jmp;
  } uword_t;

  // program entry points
  localparam step_t S_HOME = 3'd0;
  localparam step_t S_ENQ  = 3'd1;
  localparam step_t S_DEQ  = 3'd2;
  localparam step_t S_READ = 3'd4;
  localparam step_t S_NOP  = 3'd7;

  localparam int UCODE_LEN = 8;

  localparam uword_t UCODE [UCODE_LEN] = '{
    '{act: A_IDLE,    jmp: J_KIND},
    '{act: A_ENQ,     jmp: J_HOME},
    '{act: A_DEQ_CHK, jmp: J_HOME_EMPTY},
    '{act: A_DEQ_OUT, jmp: J_HOME},
    '{act: A_RD_CHK,  jmp: J_HOME_EMPTY},
    '{act: A_RD_ADDR, jmp: J_NEXT},
    '{act: A_RD_OUT,  jmp: J_HOME},
    '{act: A_NOP,     jmp: J_HOME}
  };

  localparam step_t DISPATCH [4] = '{S_ENQ, S_DEQ, S_READ, S_NOP};

  typedef struct packed {
    act_t act;
    logic go;
    logic emit;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/srtq_seq.sv
// srtq_seq: step counter and microcode fetch with conditional jumps.
// Depends on srtq_pkg (UCODE, DISPATCH, ctl_t, dp_stat_t).
module srtq_seq
  import srtq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [KIND_W-1:0]   in_kind,
  input  dp_stat_t            stat,
  output ctl_t                ctl,
  output logic                at_home
);

  step_t  step_r, step_nxt;
  step_t  target;
  uword_t uw;
  logic   emit;
  logic   go;

  always_comb begin
    uw = UCODE[step_r];
    unique case (uw.jmp)
      J_KIND:       target = DISPATCH[in_kind];
      J_NEXT:       target = step_r + step_t'(1);
      J_HOME:       target = S_HOME;
      J_HOME_EMPTY: target = stat.empty ? S_HOME : step_r + step_t'(1);
      default:      target = S_HOME;
    endcase
    emit = (uw.jmp != J_KIND) && (target == S_HOME);
    go   = (uw.jmp == J_KIND) ? in_fire : !(emit && !stat.out_free);
    step_nxt = go ? target : step_r;
    ctl.act  = uw.act;
    ctl.go   = go;
    ctl.emit = emit && go;
    ctl.load = (uw.jmp == J_KIND) && in_fire;
    at_home  = (step_r == S_HOME);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_HOME;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> hdl/srtq_dp.sv
// srtq_dp: ring pointers, sequence counter, slot memory and result register.
// Depends on srtq_pkg; driven by the control word from srtq_seq.
module srtq_dp
  import srtq_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  input  logic [PAYLOAD_BITS-1:0]  in_payload,
  input  logic [LAST_W-1:0]        in_last,
  input  logic                     out_tready,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [PAYLOAD_BITS-1:0]  out_payload,
  output logic [SEQ_W-1:0]         out_seq
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int ENT_W = SEQ_W + PAYLOAD_BITS;

  logic [ENT_W-1:0]        slot_r [DEPTH];
  logic [ENT_W-1:0]        mem_q_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [LAST_W-1:0]       last_r;
  logic [AW-1:0]           head_r, tail_r, off_r;
  logic [CW-1:0]           count_r;
  logic [SEQ_W-1:0]        next_seq_r;
  logic                    hit_r, skip_r;
  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic [SEQ_W-1:0]        out_seq_r;

  logic                    empty, full, refuse;
  logic [SEQ_W-1:0]        oldest;
  logic signed [LAST_W:0]  want, old_s, nxt_s, diff;
  logic [AW:0]             idx_sum;
  logic [AW-1:0]           idx, rd_addr;
  logic                    rd_en, wr_en;
  logic [STAT_W-1:0]       res_status;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [SEQ_W-1:0]        res_seq;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  always_comb begin
    empty   = (count_r == '0);
    full    = (count_r == CW'(DEPTH));
    refuse  = full || (next_seq_r == SEQ_MAX);
    oldest  = next_seq_r - SEQ_W'(count_r);
    want    = $signed({last_r[LAST_W-1], last_r}) + 33'sd1;
    old_s   = $signed({2'b00, oldest});
    nxt_s   = $signed({2'b00, next_seq_r});
    diff    = want - old_s;
    idx_sum = {1'b0, head_r} + {1'b0, off_r};
    idx     = (idx_sum >= (AW+1)'(DEPTH)) ? AW'(idx_sum - (AW+1)'(DEPTH)) : idx_sum[AW-1:0];
    rd_addr = (ctl.act == A_RD_ADDR && hit_r) ? idx : head_r;
    rd_en   = ctl.go && (ctl.act == A_DEQ_CHK || ctl.act == A_RD_ADDR);
    wr_en   = ctl.go && (ctl.act == A_ENQ) && !refuse;
  end

  always_comb begin
    res_status  = ST_DONE;
    res_payload = '0;
    res_seq     = '0;
    unique case (ctl.act)
      A_ENQ: begin
        if (refuse) begin
          res_status = ST_FULL;
        end else begin
          res_seq = next_seq_r;
        end
      end
      A_DEQ_CHK, A_RD_CHK: begin
        res_status = ST_EMPTY;
      end
      A_DEQ_OUT: begin
        res_payload = mem_q_r[PAYLOAD_BITS-1:0];
        res_seq     = mem_q_r[ENT_W-1:PAYLOAD_BITS];
      end
      A_RD_OUT: begin
        if (hit_r || skip_r) begin
          res_status  = hit_r ? ST_DONE : ST_SKIP;
          res_payload = mem_q_r[PAYLOAD_BITS-1:0];
          res_seq     = mem_q_r[ENT_W-1:PAYLOAD_BITS];
        end else begin
          res_status = ST_NONE;
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  // slot store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[tail_r] <= {next_seq_r, pay_r};
    end
    if (rd_en) begin
      mem_q_r <= slot_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pay_r  <= in_payload;
      last_r <= in_last;
    end
    if (ctl.go && ctl.act == A_RD_CHK) begin
      hit_r  <= (want >= old_s) && (want < nxt_s);
      skip_r <= (want < old_s);
      off_r  <= diff[AW-1:0];
    end
    if (ctl.emit) begin
      out_status_r  <= res_status;
      out_payload_r <= res_payload;
      out_seq_r     <= res_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      next_seq_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        tail_r     <= ring_next(tail_r);
        count_r    <= count_r + CW'(1);
        next_seq_r <= next_seq_r + SEQ_W'(1);
      end
      if (ctl.go && ctl.act == A_DEQ_OUT) begin
        head_r  <= ring_next(head_r);
        count_r <= count_r - CW'(1);
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.empty    = empty;
  assign stat.out_free = !out_valid_r || out_tready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_payload   = out_payload_r;
  assign out_seq       = out_seq_r;

endmodule

>>> hdl/sequenced_ring_topic_queue_core.sv
// Sequenced ring queue, top level. Program per request kind, from the home step that accepts:
// enqueue or unused kind: one action step; dequeue: check, output; read-next: check, address,
// output; an empty ring ends both at the check. Results are registered, slot data by a registered read.
// One request in flight; a waiting result stalls the program.
// Reset is synchronous, active low: clears step counter, pointers, fill count,
// sequence counter and output valid; the slot memory is not cleared.
module sequenced_ring_topic_queue_core
  import srtq_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32,
  localparam int IN_W  = ((PAYLOAD_BITS + LAST_W + 7) / 8) * 8,
  localparam int OUT_W = ((PAYLOAD_BITS + SEQ_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,   // payload_in, last_seen
  input  logic [KIND_W-1:0]   in_tuser,   // kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // payload_out, seq_out
  output logic [STAT_W-1:0]   out_tuser   // status
);

  ctl_t                    ctl;
  dp_stat_t                stat;
  logic                    at_home;
  logic                    in_fire;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [SEQ_W-1:0]        out_seq;

  assign in_tready = rst_n && at_home;
  assign in_fire   = in_tvalid && in_tready;

  srtq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_kind (in_tuser),
    .stat    (stat),
    .ctl     (ctl),
    .at_home (at_home)
  );

  srtq_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_payload  (in_tdata[PAYLOAD_BITS-1:0]),
    .in_last     (in_tdata[PAYLOAD_BITS +: LAST_W]),
    .out_tready  (out_tready),
    .stat        (stat),
    .out_valid   (out_tvalid),
    .out_status  (out_tuser),
    .out_payload (out_payload),
    .out_seq     (out_seq)
  );

  assign out_tdata = OUT_W'({out_seq, out_payload});

endmodule

>>> hdl/srtq_chk.sv
// srtq_chk: port-level checks of the sequenced ring queue, bound to the top level.
// Depends on srtq_pkg and sequenced_ring_topic_queue_core.
module srtq_chk
  import srtq_pkg::*;
#(
  parameter int PAYLOAD_BITS = 32,
  localparam int OUT_W = ((PAYLOAD_BITS + SEQ_W + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata,
  input logic [STAT_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while one is in progress");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_SKIP)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_EMPTY || out_tuser == ST_NONE)
      |-> out_tdata == '0)
    else $error("failed request carries data");

endmodule

bind sequenced_ring_topic_queue_core srtq_chk #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_srtq_chk (.*);

>>> test/sequenced_ring_topic_queue_checker.sv
// Result checker for the sequenced ring queue: watches both stream channels,
// predicts each request's result and compares it in order. Depends on srtq_pkg.
`timescale 1ns / 1ps
module sequenced_ring_topic_queue_checker
  import srtq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int PAY_W = 32,
  parameter int IN_W  = 64,
  parameter int OUT_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // payload_in, last_seen
  input  logic [KIND_W-1:0] in_tuser,   // kind
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,  // payload_out, seq_out
  input  logic [STAT_W-1:0] out_tuser,  // status
  output int                err_count,
  output int                n_pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAY_W-1:0]  payload;
    logic [SEQ_W-1:0]  seq;
  } ring_result_t;

  logic [PAY_W-1:0] ring_payload [DEPTH];
  logic [SEQ_W-1:0] ring_seq     [DEPTH];
  bit               ring_valid   [DEPTH];
  int               ring_head;
  int               ring_tail;
  bit               ring_empty;
  logic [SEQ_W-1:0] ring_next_seq;

  ring_result_t expected_results [$];

  function automatic int ring_wrap(input int idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic ring_result_t predict_ring_op(input logic [KIND_W-1:0] kind,
                                                   input logic [PAY_W-1:0] pay,
                                                   input logic [LAST_W-1:0] last);
    ring_result_t r;
    longint       want;
    bit           newer;
    bit           have_old;
    int           old_idx;
    r        = '{status: ST_DONE, payload: '0, seq: '0};
    newer    = 1'b0;
    have_old = 1'b0;
    old_idx  = 0;
    want     = longint'($signed(last)) + 1;
    case (kind)
      K_ENQ: begin
        if ((!ring_empty && ring_head == ring_tail) || ring_next_seq == SEQ_MAX) begin
          r.status = ST_FULL;
        end else begin
          ring_payload[ring_tail] = pay;
          ring_seq[ring_tail]     = ring_next_seq;
          ring_valid[ring_tail]   = 1'b1;
          r.seq                   = ring_next_seq;
          ring_tail               = ring_wrap(ring_tail);
          ring_empty              = 1'b0;
          ring_next_seq           = ring_next_seq + 1'b1;
        end
      end
      K_DEQ: begin
        if (ring_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.payload             = ring_payload[ring_head];
          r.seq                 = ring_seq[ring_head];
          ring_valid[ring_head] = 1'b0;
          ring_head             = ring_wrap(ring_head);
          if (ring_head == ring_tail) ring_empty = 1'b1;
        end
      end
      K_READ: begin
        if (ring_empty) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!ring_valid[i]) continue;
            if (!have_old || ring_seq[i] < ring_seq[old_idx]) begin
              old_idx  = i;
              have_old = 1'b1;
            end
            if (longint'(ring_seq[i]) == want) begin
              r.payload = ring_payload[i];
              r.seq     = ring_seq[i];
              return r;
            end
            if (longint'(ring_seq[i]) > want) newer = 1'b1;
          end
          if (have_old && newer && longint'(ring_seq[old_idx]) > want) begin
            r.status  = ST_SKIP;
            r.payload = ring_payload[old_idx];
            r.seq     = ring_seq[old_idx];
          end else begin
            r.status = ST_NONE;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    ring_result_t exp_r;
    ring_result_t got_r;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) ring_valid[i] = 1'b0;
      ring_head     = 0;
      ring_tail     = 0;
      ring_empty    = 1'b1;
      ring_next_seq = '0;
      expected_results.delete();
      err_count     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_r = '{status: out_tuser, payload: out_tdata[PAY_W-1:0],
                  seq: out_tdata[PAY_W +: SEQ_W]};
        if (expected_results.size() == 0) begin
          if (err_count < 10)
            $display("%0t: result with no request pending: status %0d payload %h seq %0d",
                     $realtime, got_r.status, got_r.payload, got_r.seq);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r.status !== exp_r.status || got_r.payload !== exp_r.payload ||
              got_r.seq !== exp_r.seq) begin
            if (err_count < 10)
              $display("%0t: mismatch: exp %0d %h %0d, got %0d %h %0d",
                       $realtime, exp_r.status, exp_r.payload, exp_r.seq,
                       got_r.status, got_r.payload, got_r.seq);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_ring_op(in_tuser, in_tdata[PAY_W-1:0],
                                                   in_tdata[PAY_W +: LAST_W]));
    end
    n_pending = expected_results.size();
  end

endmodule

>>> test/sequenced_ring_topic_queue_core_tb.sv
// Top of the sequenced ring queue testbench: clock, reset, request stimulus with
// bursts and gaps, receiver stalls and the verdict. Needs srtq_pkg, the core and the checker.
`timescale 1ns / 1ps
module sequenced_ring_topic_queue_core_tb;
  import srtq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int PAY_W        = 32;
  localparam int IN_W         = ((PAY_W + LAST_W + 7) / 8) * 8;
  localparam int OUT_W        = ((PAY_W + SEQ_W + 7) / 8) * 8;
  localparam int RAND_ITEMS   = 1150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic [KIND_W-1:0] in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic [STAT_W-1:0] out_tuser;

  int err_count;
  int n_pending;
  int cycle_cnt;
  int enq_sent;
  int traffic_mode;
  bit hold_req;

  sequenced_ring_topic_queue_core #(
    .DEPTH(DEPTH),
    .PAYLOAD_BITS(PAY_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  sequenced_ring_topic_queue_checker #(
    .DEPTH(DEPTH),
    .PAY_W(PAY_W),
    .IN_W(IN_W),
    .OUT_W(OUT_W)
  ) u_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .err_count(err_count),
    .n_pending(n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("sequenced_ring_topic_queue_core_tb: done, errors");
    $finish;
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int  pat_mode;
    int  pat_left;
    bit  held;
    out_tready = 1'b0;
    pat_mode   = 0;
    pat_left   = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        held = 1'b1;
      end
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(8, 64);
      end
      pat_left--;
      case (pat_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) != 0);
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= pat_left[0];
      endcase
    end
  end

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [PAY_W-1:0] pay,
                          input logic [LAST_W-1:0] last);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_W'({last, pay});
    do @(posedge clk); while (!in_tready);
    if (kind == K_ENQ) enq_sent++;
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic send_random_req();
    int                roll;
    int                enq_th;
    int                deq_th;
    int                rd_th;
    logic [KIND_W-1:0] kind;
    logic [LAST_W-1:0] last;
    case (traffic_mode)
      0:       begin enq_th = 60; deq_th = 75; rd_th = 96; end
      1:       begin enq_th = 20; deq_th = 65; rd_th = 96; end
      default: begin enq_th = 30; deq_th = 40; rd_th = 96; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < enq_th)      kind = K_ENQ;
    else if (roll < deq_th) kind = K_DEQ;
    else if (roll < rd_th)  kind = K_READ;
    else                    kind = K_NOP;
    if ($urandom_range(0, 3) == 0) last = $urandom();
    else                           last = LAST_W'(enq_sent - 1 - $urandom_range(0, 24));
    send_req(kind, $urandom(), last);
  endtask

  initial begin
    int burst_left;
    in_tvalid    = 1'b0;
    in_tuser     = K_NOP;
    in_tdata     = '0;
    rst_n        = 1'b0;
    hold_req     = 1'b0;
    enq_sent     = 0;
    traffic_mode = 0;
    burst_left   = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty ring, unused kind
    send_req(K_DEQ, '0, '0);
    send_req(K_READ, '0, '1);
    send_req(K_NOP, '1, '1);
    // payload extremes, then reads hit, beyond, far out of range, below oldest
    send_req(K_ENQ, '0, '0);
    send_req(K_ENQ, '1, '1);
    send_req(K_READ, '0, 32'hFFFF_FFFF);
    send_req(K_READ, '0, 32'h0000_0000);
    send_req(K_READ, '0, 32'h7FFF_FFFE);
    send_req(K_READ, '0, 32'h7FFF_FFFF);
    send_req(K_READ, '0, 32'h8000_0000);
    send_req(K_DEQ, '0, '0);
    send_req(K_READ, '0, 32'hFFFF_FFFF);
    // fill to full, then one refused enqueue
    for (int i = 0; i < DEPTH; i++) send_req(K_ENQ, $urandom(), '0);
    idle_in(3);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) traffic_mode = $urandom_range(0, 2);
      if (i == RAND_ITEMS / 2) begin
        traffic_mode = 0;
        hold_req     = 1'b1;
      end
      send_random_req();
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_in($urandom_range(1, 8));
      end
    end
    idle_in(1);

    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("sequenced_ring_topic_queue_core_tb: done, clean");
    end else begin
      $display("sequenced_ring_topic_queue_core_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sequenced_ring_topic_queue_core.f
hdl/srtq_pkg.sv
hdl/srtq_seq.sv
hdl/srtq_dp.sv
hdl/sequenced_ring_topic_queue_core.sv
hdl/srtq_chk.sv
test/sequenced_ring_topic_queue_checker.sv
test/sequenced_ring_topic_queue_core_tb.sv
